FILE: src/bdpq_pkg.sv
package bdpq_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned Lanes = 16;
  localparam int unsigned LaneW = 4;
  localparam int unsigned DistW = 18;
  localparam int unsigned CountW = 9;

  localparam logic [1:0] CFG_COLOR_COUNT = 2'd0;
  localparam logic [1:0] CFG_TRANS_EN = 2'd1;
  localparam logic [1:0] CFG_TRANS_IDX = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUANT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic ok;
    logic [DistW-1:0] sq_dist;
  } lane_res_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic [3:0] row;
  } pipe_ctl_t;

  function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c) + 10'(d);
    return s[9:2];
  endfunction

endpackage

FILE: src/box_downsample_palette_quantizer.sv
// Palette write: accepted with no result; the next word may follow at once.
// Quantize: R = ceil(min(color_count, depth) / 16) row reads (at least one) across 16
// distance lanes, then the read, distance, tree and merge pipeline before out_valid_o
// rises; a transparent quad skips the search and goes straight to its result.
// One word in flight at a time: the next word is taken only after the result is loaded.
// Reset is asynchronous, active low; palette contents are undefined until written.
module box_downsample_palette_quantizer #(
  parameter int unsigned PALETTE_DEPTH = bdpq_pkg::PaletteDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic req_type_i,
  input  logic [7:0] palette_slot_i,
  input  logic [23:0] palette_rgb_i,
  input  logic [31:0] pixel_top_left_i,
  input  logic [31:0] pixel_top_right_i,
  input  logic [31:0] pixel_bottom_left_i,
  input  logic [31:0] pixel_bottom_right_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [7:0] color_index_o
);

  localparam int unsigned Rows = (PALETTE_DEPTH + bdpq_pkg::Lanes - 1) / bdpq_pkg::Lanes;
  localparam int unsigned RW = (Rows > 1) ? $clog2(Rows) : 1;

  bdpq_pkg::state_e state_q, state_d;
  logic [8:0] count_q;
  logic ten_q;
  logic [7:0] tidx_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [RW-1:0] row_q, row_d, last_q, last_d;
  logic [7:0] result_q, result_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] out_idx_q, out_idx_d;
  bdpq_pkg::pipe_ctl_t ctl0, ctl1_q, ctl2_q;
  bdpq_pkg::lane_res_t lane_res [bdpq_pkg::Lanes];
  logic [bdpq_pkg::Lanes-1:0] qual;
  logic merge_done;
  logic [7:0] merge_idx;
  logic accept, is_write, is_quant, trans_hit, slot_ok, can_out;
  logic [7:0] avg_a, avg_r, avg_g, avg_b;
  logic [8:0] n_eff;
  logic [4:0] rows_need;

  assign accept = in_valid_i && in_ready_o;
  assign is_write = accept && (req_type_i == bdpq_pkg::REQ_WRITE);
  assign is_quant = accept && (req_type_i == bdpq_pkg::REQ_QUANT);
  assign slot_ok = 9'(palette_slot_i) < 9'(PALETTE_DEPTH);
  assign can_out = !out_valid_q || out_ready_i;

  assign avg_a = bdpq_pkg::avg4(pixel_top_left_i[31:24], pixel_top_right_i[31:24],
                                pixel_bottom_left_i[31:24], pixel_bottom_right_i[31:24]);
  assign avg_r = bdpq_pkg::avg4(pixel_top_left_i[23:16], pixel_top_right_i[23:16],
                                pixel_bottom_left_i[23:16], pixel_bottom_right_i[23:16]);
  assign avg_g = bdpq_pkg::avg4(pixel_top_left_i[15:8], pixel_top_right_i[15:8],
                                pixel_bottom_left_i[15:8], pixel_bottom_right_i[15:8]);
  assign avg_b = bdpq_pkg::avg4(pixel_top_left_i[7:0], pixel_top_right_i[7:0],
                                pixel_bottom_left_i[7:0], pixel_bottom_right_i[7:0]);
  assign trans_hit = (avg_a == 8'd0) && ten_q;

  assign n_eff = (count_q < 9'(PALETTE_DEPTH)) ? count_q : 9'(PALETTE_DEPTH);
  assign rows_need = 5'((10'(n_eff) + 10'(bdpq_pkg::Lanes - 1)) >> bdpq_pkg::LaneW);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdpq_pkg::S_IDLE: begin
        if (is_quant) begin
          state_d = trans_hit ? bdpq_pkg::S_FINISH : bdpq_pkg::S_ISSUE;
        end
      end
      bdpq_pkg::S_ISSUE: begin
        if (row_q == last_q) begin
          state_d = bdpq_pkg::S_DRAIN;
        end
      end
      bdpq_pkg::S_DRAIN: begin
        if (merge_done) begin
          state_d = bdpq_pkg::S_FINISH;
        end
      end
      bdpq_pkg::S_FINISH: begin
        if (can_out) begin
          state_d = bdpq_pkg::S_IDLE;
        end
      end
      default: state_d = bdpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    row_d = row_q;
    last_d = last_q;
    result_d = result_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d = out_idx_q;
    ctl0 = '0;
    unique case (state_q)
      bdpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        row_d = '0;
        last_d = (rows_need == 5'd0) ? '0 : RW'(rows_need - 5'd1);
        result_d = tidx_q;
      end
      bdpq_pkg::S_ISSUE: begin
        row_d = row_q + RW'(1);
        ctl0.vld = 1'b1;
        ctl0.first = (row_q == '0);
        ctl0.last = (row_q == last_q);
        ctl0.row = 4'(row_q);
      end
      bdpq_pkg::S_DRAIN: begin
        if (merge_done) begin
          result_d = merge_idx;
        end
      end
      bdpq_pkg::S_FINISH: begin
        if (can_out) begin
          out_valid_d = 1'b1;
          out_idx_d = result_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdpq_pkg::S_IDLE;
      count_q <= 9'd256;
      ten_q <= 1'b0;
      tidx_q <= 8'd0;
      row_q <= '0;
      last_q <= '0;
      out_valid_q <= 1'b0;
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      last_q <= last_d;
      out_valid_q <= out_valid_d;
      ctl1_q <= ctl0;
      ctl2_q <= ctl1_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bdpq_pkg::CFG_COLOR_COUNT: count_q <= cfg_data_i;
          bdpq_pkg::CFG_TRANS_EN: ten_q <= cfg_data_i[0];
          bdpq_pkg::CFG_TRANS_IDX: tidx_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    out_idx_q <= out_idx_d;
    if (is_quant) begin
      red_q <= avg_r;
      green_q <= avg_g;
      blue_q <= avg_b;
    end
  end

  for (genvar l = 0; l < bdpq_pkg::Lanes; l++) begin : g_lane
    logic [8:0] idx;
    assign idx = (9'(row_q) << bdpq_pkg::LaneW) | 9'(l);
    assign qual[l] = (idx < n_eff) && !(ten_q && idx[7:0] == tidx_q && !idx[8]);

    bdpq_lane #(
      .ROWS(Rows),
      .RW(RW)
    ) u_lane (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .we_i(is_write && slot_ok && palette_slot_i[bdpq_pkg::LaneW-1:0] == 4'(l)),
      .waddr_i(RW'(palette_slot_i >> bdpq_pkg::LaneW)),
      .wdata_i(palette_rgb_i),
      .raddr_i(row_q),
      .qual_i(qual[l] && state_q == bdpq_pkg::S_ISSUE),
      .red_i(red_q),
      .green_i(green_q),
      .blue_i(blue_q),
      .res_o(lane_res[l])
    );
  end

  bdpq_merge u_merge (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctl_i(ctl2_q),
    .res_i(lane_res),
    .done_o(merge_done),
    .index_o(merge_idx)
  );

  assign out_valid_o = out_valid_q;
  assign color_index_o = out_idx_q;

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> state_q == bdpq_pkg::S_DRAIN)
    else $error("search finished outside drain");

  a_quant_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_quant && !trans_hit) |=> state_q == bdpq_pkg::S_ISSUE)
    else $error("search did not start");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdpq_pkg::S_FINISH && can_out) |=>
      (out_valid_o && state_q == bdpq_pkg::S_IDLE))
    else $error("result not loaded");

endmodule

FILE: src/bdpq_lane.sv
module bdpq_lane #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned RW = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic we_i,
  input  logic [RW-1:0] waddr_i,
  input  logic [23:0] wdata_i,
  input  logic [RW-1:0] raddr_i,
  input  logic qual_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output bdpq_pkg::lane_res_t res_o
);

  logic [23:0] mem [ROWS];
  logic [23:0] rdata_q;
  logic qual_q;
  bdpq_pkg::lane_res_t res_q, res_d;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qual_q <= 1'b0;
      res_q <= '0;
    end else begin
      qual_q <= qual_i;
      res_q <= res_d;
    end
  end

  always_comb begin
    logic [7:0] dr, dg, db;
    dr = (red_i > rdata_q[23:16]) ? red_i - rdata_q[23:16] : rdata_q[23:16] - red_i;
    dg = (green_i > rdata_q[15:8]) ? green_i - rdata_q[15:8] : rdata_q[15:8] - green_i;
    db = (blue_i > rdata_q[7:0]) ? blue_i - rdata_q[7:0] : rdata_q[7:0] - blue_i;
    res_d.ok = qual_q;
    res_d.sq_dist = bdpq_pkg::DistW'(dr * dr) + bdpq_pkg::DistW'(dg * dg)
                  + bdpq_pkg::DistW'(db * db);
  end

  assign res_o = res_q;

endmodule

FILE: src/bdpq_merge.sv
module bdpq_merge (
  input  logic clk_i,
  input  logic rst_ni,
  input  bdpq_pkg::pipe_ctl_t ctl_i,
  input  bdpq_pkg::lane_res_t res_i [bdpq_pkg::Lanes],
  output logic done_o,
  output logic [7:0] index_o
);

  bdpq_pkg::pipe_ctl_t ctl_q;
  logic a_ok_q;
  logic [bdpq_pkg::DistW-1:0] a_dist_q;
  logic [bdpq_pkg::LaneW-1:0] a_lane_q;
  logic t_ok;
  logic [bdpq_pkg::DistW-1:0] t_dist;
  logic [bdpq_pkg::LaneW-1:0] t_lane;
  logic best_ok_q, best_ok_d;
  logic [bdpq_pkg::DistW-1:0] best_dist_q, best_dist_d;
  logic [7:0] best_idx_q, best_idx_d;
  logic done_q;

  // Pairwise tree; on a tie the lower lane is kept.
  always_comb begin
    logic ok [bdpq_pkg::Lanes];
    logic [bdpq_pkg::DistW-1:0] d [bdpq_pkg::Lanes];
    logic [bdpq_pkg::LaneW-1:0] ix [bdpq_pkg::Lanes];
    for (int j = 0; j < bdpq_pkg::Lanes; j++) begin
      ok[j] = res_i[j].ok;
      d[j] = res_i[j].sq_dist;
      ix[j] = bdpq_pkg::LaneW'(j);
    end
    for (int s = 1; s < bdpq_pkg::Lanes; s = s * 2) begin
      for (int j = 0; j + s < bdpq_pkg::Lanes; j = j + 2 * s) begin
        if (ok[j+s] && (!ok[j] || d[j+s] < d[j])) begin
          ok[j] = 1'b1;
          d[j] = d[j+s];
          ix[j] = ix[j+s];
        end
      end
    end
    t_ok = ok[0];
    t_dist = d[0];
    t_lane = t_ok ? ix[0] : '0;
  end

  always_comb begin
    logic [7:0] a_idx;
    a_idx = a_ok_q ? {ctl_q.row, a_lane_q} : 8'd0;
    best_ok_d = best_ok_q;
    best_dist_d = best_dist_q;
    best_idx_d = best_idx_q;
    if (ctl_q.vld) begin
      if (ctl_q.first || (a_ok_q && (!best_ok_q || a_dist_q < best_dist_q))) begin
        best_ok_d = a_ok_q;
        best_dist_d = a_dist_q;
        best_idx_d = a_idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      a_ok_q <= 1'b0;
      a_dist_q <= '0;
      a_lane_q <= '0;
      best_ok_q <= 1'b0;
      best_dist_q <= '0;
      best_idx_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q <= ctl_i;
      a_ok_q <= t_ok;
      a_dist_q <= t_dist;
      a_lane_q <= t_lane;
      best_ok_q <= best_ok_d;
      best_dist_q <= best_dist_d;
      best_idx_q <= best_idx_d;
      done_q <= ctl_q.vld && ctl_q.last;
    end
  end

  assign done_o = done_q;
  assign index_o = best_idx_q;

endmodule

FILE: sim/tb_box_downsample_palette_quantizer.sv
`timescale 1ns / 1ps

module tb_box_downsample_palette_quantizer;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned SettleCycles = 64;

  typedef struct {
    logic        req;
    logic [7:0]  slot;
    logic [23:0] rgb;
    logic [31:0] px[4];
  } pix_word_t;

  class palette_scoreboard;
    logic [23:0] pal[256];
    logic [8:0]  color_count;
    logic        trans_en;
    logic [7:0]  trans_idx;
    logic [7:0]  index_q[$];
    int          errors;

    function new();
      color_count = 9'd256;
      trans_en = 1'b0;
      trans_idx = 8'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        bdpq_pkg::CFG_COLOR_COUNT: color_count = data;
        bdpq_pkg::CFG_TRANS_EN: trans_en = data[0];
        bdpq_pkg::CFG_TRANS_IDX: trans_idx = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned chan_avg(pix_word_t w, int shift);
      int unsigned sum;
      sum = 0;
      for (int k = 0; k < 4; k++) sum += (w.px[k] >> shift) & 32'hff;
      return sum >> 2;
    endfunction

    function int unsigned sq(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function void note_word(pix_word_t w);
      int unsigned r, g, b, n, best, best_d, d;
      if (w.req == bdpq_pkg::REQ_WRITE) begin
        pal[w.slot] = w.rgb;
        return;
      end
      if (chan_avg(w, 24) == 0 && trans_en) begin
        index_q.push_back(trans_idx);
        return;
      end
      r = chan_avg(w, 16);
      g = chan_avg(w, 8);
      b = chan_avg(w, 0);
      n = (32'(color_count) < 256) ? 32'(color_count) : 256;
      best = 0;
      best_d = 255 * 255 * 255;
      for (int unsigned i = 0; i < n; i++) begin
        if (trans_en && i == 32'(trans_idx)) continue;
        d = sq(r, 32'(pal[i][23:16])) + sq(g, 32'(pal[i][15:8])) + sq(b, 32'(pal[i][7:0]));
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      index_q.push_back(best[7:0]);
    endfunction

    function void check_index(logic [7:0] got);
      logic [7:0] exp_idx;
      if (index_q.size() == 0) begin
        $error("color_index: unexpected word, actual %0d", got);
        errors++;
        return;
      end
      exp_idx = index_q.pop_front();
      if (got !== exp_idx) begin
        $error("color_index: expected %0d, actual %0d", exp_idx, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [8:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  palette_slot_i;
  logic [23:0] palette_rgb_i;
  logic [31:0] pixel_top_left_i;
  logic [31:0] pixel_top_right_i;
  logic [31:0] pixel_bottom_left_i;
  logic [31:0] pixel_bottom_right_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  color_index_o;

  palette_scoreboard sb = new();
  int unsigned idle_pct = 28;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  box_downsample_palette_quantizer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .palette_slot_i, .palette_rgb_i,
    .pixel_top_left_i, .pixel_top_right_i, .pixel_bottom_left_i,
    .pixel_bottom_right_i, .out_valid_o, .out_ready_i, .color_index_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pix_word_t w;
    if (in_valid_i && in_ready_o) begin
      w.req = req_type_i;
      w.slot = palette_slot_i;
      w.rgb = palette_rgb_i;
      w.px[0] = pixel_top_left_i;
      w.px[1] = pixel_top_right_i;
      w.px[2] = pixel_bottom_left_i;
      w.px[3] = pixel_bottom_right_i;
      sb.note_word(w);
    end
    if (out_valid_o && out_ready_i) sb.check_index(color_index_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_word(pix_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i = w.req;
    palette_slot_i = w.slot;
    palette_rgb_i = w.rgb;
    pixel_top_left_i = w.px[0];
    pixel_top_right_i = w.px[1];
    pixel_bottom_left_i = w.px[2];
    pixel_bottom_right_i = w.px[3];
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.index_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic pix_word_t write_word(logic [7:0] slot, logic [23:0] rgb);
    pix_word_t w;
    w.req = bdpq_pkg::REQ_WRITE;
    w.slot = slot;
    w.rgb = rgb;
    for (int k = 0; k < 4; k++) w.px[k] = $urandom();
    return w;
  endfunction

  function automatic pix_word_t quad_word(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    pix_word_t w;
    w.req = bdpq_pkg::REQ_QUANT;
    w.slot = 8'($urandom());
    w.rgb = 24'($urandom());
    w.px[0] = a;
    w.px[1] = b;
    w.px[2] = c;
    w.px[3] = d;
    return w;
  endfunction

  function automatic pix_word_t random_word();
    pix_word_t w;
    logic [23:0] c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      c = ($urandom_range(1) == 0) ? 24'($urandom()) : sb.pal[$urandom_range(255)];
      return write_word(8'($urandom()), c);
    end
    w = quad_word($urandom(), $urandom(), $urandom(), $urandom());
    if (pick < 40) begin
      for (int k = 0; k < 4; k++) w.px[k][31:24] = 8'd0;
      w.px[$urandom_range(3)][31:24] = 8'($urandom_range(3));
    end else if (pick < 70) begin
      c = sb.pal[$urandom_range(255)];
      for (int k = 0; k < 4; k++) w.px[k][23:0] = c;
    end else if (pick < 75) begin
      for (int k = 0; k < 4; k++) w.px[k] = ($urandom_range(1) == 0) ? '0 : '1;
    end
    return w;
  endfunction

  task automatic run_phase(logic [8:0] cc, logic te, logic [7:0] ti,
                           int unsigned pct, int unsigned n, bit squeeze);
    drain_block();
    write_reg(bdpq_pkg::CFG_COLOR_COUNT, cc);
    write_reg(bdpq_pkg::CFG_TRANS_EN, {8'd0, te});
    write_reg(bdpq_pkg::CFG_TRANS_IDX, {1'b0, ti});
    idle_pct = pct;
    if (squeeze) hold_req = 1'b1;
    send_word(quad_word('0, '0, '0, '0));
    send_word(quad_word('1, '1, '1, '1));
    send_word(quad_word(32'h00ffffff, 32'h00ffffff, 32'h00ffffff, 32'h03ffffff));
    for (int unsigned i = 0; i < n; i++) send_word(random_word());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bdpq_pkg::CFG_COLOR_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = bdpq_pkg::REQ_WRITE;
    palette_slot_i = '0;
    palette_rgb_i = '0;
    pixel_top_left_i = '0;
    pixel_top_right_i = '0;
    pixel_bottom_left_i = '0;
    pixel_bottom_right_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The whole palette is filled first so that no search reads an unwritten entry.
    idle_pct = 0;
    for (int i = 0; i < 256; i++) begin
      if (i == 0) send_word(write_word(8'(i), 24'h000000));
      else if (i == 255) send_word(write_word(8'(i), 24'hffffff));
      else if (i == 7) send_word(write_word(8'(i), sb.pal[3]));
      else send_word(write_word(8'(i), 24'($urandom())));
    end
    idle_pct = 28;
    send_word(quad_word(32'hff000000, 32'h00ff0000, 32'h0000ff00, 32'h000000ff));
    send_word(quad_word(32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000));
    send_word(quad_word({8'h00, sb.pal[3]}, {8'h00, sb.pal[3]}, {8'h00, sb.pal[3]},
                        {8'h00, sb.pal[3]}));

    run_phase(9'd256, 1'b0, 8'd0, 28, 120, 1'b1);
    run_phase(9'd1, 1'b1, 8'd0, 28, 50, 1'b0);
    run_phase(9'd0, 1'b0, 8'd0, 28, 40, 1'b0);
    run_phase(9'd511, 1'b1, 8'd255, 0, 170, 1'b0);
    run_phase(9'd17, 1'b1, 8'd200, 28, 150, 1'b0);
    run_phase(9'd1, 1'b0, 8'd9, 28, 50, 1'b0);
    run_phase(9'd256, 1'b1, 8'd0, 28, 120, 1'b0);
    run_phase(9'($urandom_range(2, 255)), 1'b1, 8'($urandom()), 28, 120, 1'b0);

    drain_block();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bdpq_pkg.sv
src/bdpq_lane.sv
src/bdpq_merge.sv
src/box_downsample_palette_quantizer.sv
sim/tb_box_downsample_palette_quantizer.sv
